FILE: rtl/core/afc_pkg.sv
package afc_pkg;

  // Field formats
  localparam int CoordWidth = 20;
  localparam int CoordFrac  = 4;
  localparam int AxisWidth  = 16;
  localparam int AxisFrac   = AxisWidth - 2;
  localparam int SlopeWidth = 16;
  localparam int SlopeFrac  = SlopeWidth - 4;
  localparam int Corners    = 8;

  // Packed register widths
  localparam int AxisRegWidth  = 3 * AxisWidth;
  localparam int PosRegWidth   = 3 * CoordWidth;
  localparam int CfgDataWidth  = (PosRegWidth > AxisRegWidth) ? PosRegWidth : AxisRegWidth;
  localparam int CfgIndexWidth = 3;

  // Datapath widths, each exact for its operands
  localparam int RelWidth   = CoordWidth + 1;          // corner minus camera
  localparam int ProdWidth  = RelWidth + AxisWidth;    // axis component times offset
  localparam int DotWidth   = ProdWidth + 2;           // sum of three products
  localparam int ScaleWidth = DotWidth + SlopeWidth + 2; // slope times depth, and negated
  localparam int DepthWidth = DotWidth + AxisWidth;    // depth compare against planes

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgRightAxis   = 3'd0,
    CfgUpAxis      = 3'd1,
    CfgForwardAxis = 3'd2,
    CfgCameraPos   = 3'd3,
    CfgXSlope      = 3'd4,
    CfgYSlope      = 3'd5,
    CfgNearDist    = 3'd6,
    CfgFarDist     = 3'd7
  } cfg_idx_e;

  // Register reset values
  localparam logic [AxisRegWidth-1:0] RightAxisRst   = AxisRegWidth'(48'h0000_0000_4000);
  localparam logic [AxisRegWidth-1:0] UpAxisRst      = AxisRegWidth'(48'h0000_4000_0000);
  localparam logic [AxisRegWidth-1:0] ForwardAxisRst = AxisRegWidth'(48'hFFFF_0000_0000);
  localparam logic [PosRegWidth-1:0]  CameraPosRst   = '0;
  localparam logic [SlopeWidth-1:0]   SlopeRst       = SlopeWidth'(16'h1000);
  localparam logic [CoordWidth-1:0]   NearDistRst    = CoordWidth'(20'h00010);
  localparam logic [CoordWidth-1:0]   FarDistRst     = CoordWidth'(20'h7FFFF);

endpackage

FILE: rtl/core/aabb_frustum_cull_core.sv
// Box-against-frustum cull. Each accepted box (min and max corners, signed Q16.4)
// yields one visible flag, 0 only when all eight corners lie outside the same one
// of the six frustum planes. The datapath is a five-stage pipeline: camera offset,
// axis products, dot sums, slope-times-depth products, plane compares. One box
// enters per cycle while the output is not stalled. A stall on the output
// holds every stage, so in_stall_o follows out_stall_i while a result is waiting.
// Camera and frustum registers are written through the cfg port, which is always
// ready; write them only while the pipeline is empty.
module aabb_frustum_cull_core
  import afc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [CfgDataWidth-1:0]      cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [CoordWidth-1:0] min_x_i,
  input  logic signed [CoordWidth-1:0] min_y_i,
  input  logic signed [CoordWidth-1:0] min_z_i,
  input  logic signed [CoordWidth-1:0] max_x_i,
  input  logic signed [CoordWidth-1:0] max_y_i,
  input  logic signed [CoordWidth-1:0] max_z_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         visible_o
);

  // Configuration registers
  logic [AxisRegWidth-1:0] right_q, up_q, fwd_q;
  logic [PosRegWidth-1:0]  pos_q;
  logic [SlopeWidth-1:0]   xs_q, ys_q;
  logic [CoordWidth-1:0]   near_q, far_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= RightAxisRst;
      up_q    <= UpAxisRst;
      fwd_q   <= ForwardAxisRst;
      pos_q   <= CameraPosRst;
      xs_q    <= SlopeRst;
      ys_q    <= SlopeRst;
      near_q  <= NearDistRst;
      far_q   <= FarDistRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgRightAxis:   right_q <= cfg_data_i[AxisRegWidth-1:0];
        CfgUpAxis:      up_q    <= cfg_data_i[AxisRegWidth-1:0];
        CfgForwardAxis: fwd_q   <= cfg_data_i[AxisRegWidth-1:0];
        CfgCameraPos:   pos_q   <= cfg_data_i[PosRegWidth-1:0];
        CfgXSlope:      xs_q    <= cfg_data_i[SlopeWidth-1:0];
        CfgYSlope:      ys_q    <= cfg_data_i[SlopeWidth-1:0];
        CfgNearDist:    near_q  <= cfg_data_i[CoordWidth-1:0];
        CfgFarDist:     far_q   <= cfg_data_i[CoordWidth-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: hold every stage while the output transfer is blocked
  logic advance;
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Stage 1: offsets from camera, [corner select][axis x,y,z]
  logic signed [CoordWidth-1:0] box_c [2][3];
  logic signed [RelWidth-1:0]   rel_d [2][3];
  logic signed [RelWidth-1:0]   rel_q [2][3];

  always_comb begin
    box_c[0][0] = min_x_i;
    box_c[0][1] = min_y_i;
    box_c[0][2] = min_z_i;
    box_c[1][0] = max_x_i;
    box_c[1][1] = max_y_i;
    box_c[1][2] = max_z_i;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < 3; k++) begin
        rel_d[s][k] = RelWidth'(box_c[s][k])
                    - RelWidth'($signed(pos_q[k*CoordWidth +: CoordWidth]));
      end
    end
  end

  // Stage 2: each axis component times both offsets, [vector][component][select]
  logic signed [ProdWidth-1:0] prod_d [3][3][2];
  logic signed [ProdWidth-1:0] prod_q [3][3][2];
  logic signed [AxisWidth-1:0] axis_c [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axis_c[0][k] = $signed(right_q[k*AxisWidth +: AxisWidth]);
      axis_c[1][k] = $signed(up_q[k*AxisWidth +: AxisWidth]);
      axis_c[2][k] = $signed(fwd_q[k*AxisWidth +: AxisWidth]);
    end
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        for (int s = 0; s < 2; s++) begin
          prod_d[a][k][s] = ProdWidth'(axis_c[a][k]) * ProdWidth'(rel_q[s][k]);
        end
      end
    end
  end

  // Stage 3: camera-space coordinates of all corners, [corner][vector]
  logic signed [DotWidth-1:0] dot_d [Corners][3];
  logic signed [DotWidth-1:0] dot_q [Corners][3];

  always_comb begin
    for (int c = 0; c < Corners; c++) begin
      for (int a = 0; a < 3; a++) begin
        dot_d[c][a] = DotWidth'(prod_q[a][0][c % 2])
                    + DotWidth'(prod_q[a][1][(c / 4) % 2])
                    + DotWidth'(prod_q[a][2][(c / 2) % 2]);
      end
    end
  end

  // Stage 4: slope times depth per corner
  logic signed [DotWidth-1:0]   cam_q [Corners][3];
  logic signed [ScaleWidth-1:0] bx_d [Corners];
  logic signed [ScaleWidth-1:0] by_d [Corners];
  logic signed [ScaleWidth-1:0] bx_q [Corners];
  logic signed [ScaleWidth-1:0] by_q [Corners];
  logic signed [ScaleWidth-1:0] xs_c, ys_c;

  always_comb begin
    xs_c = ScaleWidth'($signed({1'b0, xs_q}));
    ys_c = ScaleWidth'($signed({1'b0, ys_q}));
    for (int c = 0; c < Corners; c++) begin
      bx_d[c] = xs_c * ScaleWidth'(dot_q[c][2]);
      by_d[c] = ys_c * ScaleWidth'(dot_q[c][2]);
    end
  end

  // Stage 5: plane compares and the all-corners-outside vote
  logic signed [ScaleWidth-1:0] lx_c, ly_c;
  logic signed [DepthWidth-1:0] cz_c, nearz_c, farz_c;
  logic [Corners-1:0] left_c, right_c, bottom_c, top_c, near_c, far_c;
  logic               visible_d, visible_q;

  always_comb begin
    nearz_c = DepthWidth'($signed(near_q)) <<< AxisFrac;
    farz_c  = DepthWidth'($signed(far_q)) <<< AxisFrac;
    lx_c    = '0;
    ly_c    = '0;
    cz_c    = '0;
    for (int c = 0; c < Corners; c++) begin
      lx_c = ScaleWidth'(cam_q[c][0]) <<< SlopeFrac;
      ly_c = ScaleWidth'(cam_q[c][1]) <<< SlopeFrac;
      cz_c = DepthWidth'(cam_q[c][2]);
      left_c[c]   = lx_c < -bx_q[c];
      right_c[c]  = !left_c[c] && (bx_q[c] < lx_c);
      bottom_c[c] = ly_c < -by_q[c];
      top_c[c]    = !bottom_c[c] && (by_q[c] < ly_c);
      near_c[c]   = cz_c < nearz_c;
      far_c[c]    = !near_c[c] && (cz_c > farz_c);
    end
    visible_d = !((&left_c) || (&right_c) || (&bottom_c) || (&top_c)
                  || (&near_c) || (&far_c));
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rel_q     <= rel_d;
      prod_q    <= prod_d;
      dot_q     <= dot_d;
      cam_q     <= dot_q;
      bx_q      <= bx_d;
      by_q      <= by_d;
      visible_q <= visible_d;
    end
  end

  assign visible_o = visible_q;

endmodule
